>>> rtl/seven_segment_text_display_assert.svh
// Assertion macros used by the checker module of the seven-segment text display.
// Needs nothing else; included by bare file name.
`ifndef SEVEN_SEGMENT_TEXT_DISPLAY_ASSERT_SVH
`define SEVEN_SEGMENT_TEXT_DISPLAY_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SSTD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sstd_pkg.sv
// Package of the seven-segment text display: font table, character codes, item type.
// No dependencies; used by every module of the block by scoped names.
package sstd_pkg;

	localparam int DIGIT_COUNT_DEF = 4;

	// request kinds
	localparam logic MODE_CHAR = 1'b0;
	localparam logic MODE_SCAN = 1'b1;

	// control characters
	localparam logic [7:0] CH_BS     = 8'd8;
	localparam logic [7:0] CH_LF     = 8'd10;
	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] CH_COMMA  = 8'd44;
	localparam logic [7:0] CH_PERIOD = 8'd46;

	localparam logic [7:0] GLYPH_BASE = 8'd32;
	localparam logic [7:0] GLYPH_LAST = 8'd127;
	localparam logic [7:0] CURSOR_MAX = 8'd255;
	localparam logic [7:0] BLANK      = 8'h00;
	localparam logic [7:0] DP_MASK    = 8'h01;

	// segments a..g,dp on bits 7..0, first entry is space
	localparam logic [7:0] GLYPHS [0:95] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h9c, 8'hf0, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00,
		8'hfc, 8'h60, 8'hda, 8'hf2, 8'h66, 8'hb6, 8'hbe, 8'he0,
		8'hfe, 8'hf6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'hee, 8'h3e, 8'h9c, 8'h7a, 8'h9e, 8'h8e, 8'hbc,
		8'h6e, 8'h0c, 8'h70, 8'h00, 8'h1c, 8'h00, 8'h2a, 8'hfc,
		8'hce, 8'he6, 8'h0a, 8'hb6, 8'h1e, 8'h7c, 8'h00, 8'h00,
		8'h00, 8'h76, 8'hda, 8'h9c, 8'h00, 8'hf0, 8'hc4, 8'h10,
		8'h00, 8'hee, 8'h3e, 8'h1a, 8'h7a, 8'hde, 8'h8e, 8'hbc,
		8'h2e, 8'h08, 8'h70, 8'h00, 8'h1c, 8'h00, 8'h2a, 8'h3a,
		8'hce, 8'he6, 8'h0a, 8'hb6, 8'h1e, 8'h38, 8'h00, 8'h00,
		8'h00, 8'h76, 8'hda, 8'h00, 8'h0c, 8'h00, 8'h00, 8'h00
	};

	typedef struct packed {
		logic       mode;
		logic [7:0] char_code;
	} item_t;

	// digit index width, at least one bit
	function automatic int idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	// font lookup; codes outside the printable range are blank
	function automatic logic [7:0] glyph_for(input logic [7:0] code);
		logic [6:0] ofs;
		ofs = 7'(code - GLYPH_BASE);
		if (code inside {[GLYPH_BASE:GLYPH_LAST]})
			return GLYPHS[ofs];
		return BLANK;
	endfunction

endpackage

>>> rtl/sstd_text_store.sv
// Digit store and cursor of the seven-segment text display.
// Depends on sstd_pkg (font, character codes).
module sstd_text_store #(
	parameter int DIGIT_COUNT = sstd_pkg::DIGIT_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [7:0]                  code,
	output logic [DIGIT_COUNT-1:0][7:0] store
);

	logic [DIGIT_COUNT-1:0][7:0] store_q;
	logic [DIGIT_COUNT-1:0][7:0] store_d;
	logic [7:0]                  cursor_q;
	logic [7:0]                  cursor_d;
	logic [7:0]                  prev_pos;
	logic [7:0]                  glyph;

	assign prev_pos = (cursor_q != 8'd0) ? cursor_q - 8'd1 : 8'd0;
	assign glyph    = sstd_pkg::glyph_for(code);

	always_comb begin
		case (code)
			sstd_pkg::CH_BS:                       cursor_d = prev_pos;
			sstd_pkg::CH_LF, sstd_pkg::CH_CR:      cursor_d = 8'd0;
			sstd_pkg::CH_PERIOD, sstd_pkg::CH_COMMA: cursor_d = cursor_q;
			default: cursor_d = (cursor_q == sstd_pkg::CURSOR_MAX) ? cursor_q
				: cursor_q + 8'd1;
		endcase
	end

	// per-digit update; cursor past the store matches no digit, so the write drops
	always_comb begin
		store_d = store_q;
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			case (code)
				sstd_pkg::CH_LF: store_d[i] = sstd_pkg::BLANK;
				sstd_pkg::CH_BS, sstd_pkg::CH_CR: store_d[i] = store_q[i];
				sstd_pkg::CH_PERIOD, sstd_pkg::CH_COMMA: begin
					if (prev_pos == 8'(i))
						store_d[i] = store_q[i] | sstd_pkg::DP_MASK;
				end
				default: begin
					if (cursor_q == 8'(i))
						store_d[i] = glyph;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q  <= '0;
			cursor_q <= 8'd0;
		end else if (wr_en) begin
			store_q  <= store_d;
			cursor_q <= cursor_d;
		end
	end

	assign store = store_q;

endmodule

>>> rtl/sstd_scan.sv
// Scan position and result register of the seven-segment text display.
// Depends on sstd_pkg (index width helper).
module sstd_scan #(
	parameter int DIGIT_COUNT = sstd_pkg::DIGIT_COUNT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic                        out_ready,
	input  logic [DIGIT_COUNT-1:0][7:0] store,
	output logic                        out_valid,
	output logic [1:0]                  digit_index,
	output logic [7:0]                  segment_bits
);

	localparam int IDX_W = sstd_pkg::idx_w(DIGIT_COUNT);

	logic [IDX_W-1:0] scan_q;
	logic [IDX_W-1:0] scan_next;
	logic [IDX_W+1:0] scan_ext;
	logic             out_valid_q;
	logic [1:0]       digit_index_q;
	logic [7:0]       segment_q;

	assign scan_next = (scan_q == IDX_W'(DIGIT_COUNT - 1)) ? '0 : scan_q + 1'b1;
	// digit index is the low two bits of the scan position
	assign scan_ext  = (IDX_W + 2)'(scan_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (fire) begin
			scan_q      <= scan_next;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			digit_index_q <= scan_ext[1:0];
			segment_q     <= store[scan_next];
		end
	end

	assign out_valid    = out_valid_q;
	assign digit_index  = digit_index_q;
	assign segment_bits = segment_q;

endmodule

>>> rtl/seven_segment_text_display.sv
// Multiplexed seven-segment text display. Each input request is either a character
// write (mode 0) or a scan tick (mode 1). Printable codes 32..127 go through a fixed
// font into the digit under the cursor and the cursor advances (saturating at 255,
// writes past the last digit dropped); codes outside that range write blank.
// Backspace steps the cursor back, newline blanks the store and homes the cursor,
// carriage return homes it, and period or comma sets the decimal point of the digit
// before the cursor. A scan tick first advances the wrapping scan position, then
// returns that digit's index and segment pattern (a..g,dp on bits 7..0); the first
// tick after reset shows digit 1. Character writes return nothing. Rate: one request
// per clock while no scan tick is held in the input stage. A request is registered in
// the input stage on acceptance and applied from there; a scan result is held in the
// result register and presented on out_valid. The only stall comes
// from the result register: while a result waits on out_ready, a scan tick behind it
// holds in the input stage and in_ready drops; character writes keep flowing past a
// waiting result up to the next scan tick.
// Depends on sstd_pkg, sstd_text_store and sstd_scan.
module seven_segment_text_display #(
	parameter int DIGIT_COUNT = sstd_pkg::DIGIT_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       mode,
	input  logic [7:0] char_code,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] digit_index,
	output logic [7:0] segment_bits
);

	logic                        valid_s1;
	sstd_pkg::item_t             item_s1;
	logic                        out_free;
	logic                        advance;
	logic                        char_wr;
	logic                        scan_fire;
	logic [DIGIT_COUNT-1:0][7:0] store;

	// result register can take a new result this cycle
	assign out_free  = !out_valid || out_ready;
	// character writes never wait; scan ticks need room in the result register
	assign advance   = valid_s1 && ((item_s1.mode == sstd_pkg::MODE_CHAR) || out_free);
	assign char_wr   = advance && (item_s1.mode == sstd_pkg::MODE_CHAR);
	assign scan_fire = advance && (item_s1.mode == sstd_pkg::MODE_SCAN);
	assign in_ready  = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.mode      <= mode;
			item_s1.char_code <= char_code;
		end
	end

	sstd_text_store #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_text_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (char_wr),
		.code   (item_s1.char_code),
		.store  (store)
	);

	sstd_scan #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (scan_fire),
		.out_ready    (out_ready),
		.store        (store),
		.out_valid    (out_valid),
		.digit_index  (digit_index),
		.segment_bits (segment_bits)
	);

endmodule

>>> rtl/sstd_checker.sv
// Port-level checks of the seven-segment text display, bound to the top level.
// Depends on sstd_pkg and seven_segment_text_display_assert.svh.
`include "seven_segment_text_display_assert.svh"

module sstd_checker #(
	parameter int DIGIT_COUNT = sstd_pkg::DIGIT_COUNT_DEF
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       mode,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] digit_index,
	input logic [7:0] segment_bits
);

	logic scan_acc;
	logic idx_ok;

	assign scan_acc = in_valid && in_ready && (mode == sstd_pkg::MODE_SCAN);
	assign idx_ok   = {3'b000, digit_index} < 5'(DIGIT_COUNT);

	`SSTD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(digit_index) && $stable(segment_bits), "result changed while stalled")
	`SSTD_ASSERT_NOW(a_idx_range, clk, arst_n, out_valid, idx_ok, "digit index beyond store")
	`SSTD_ASSERT_NOW(a_stall_cause, clk, arst_n, !in_ready, out_valid && !out_ready, "input stalled without a waiting result")
	`SSTD_ASSERT_NOW(a_result_from_tick, clk, arst_n, $rose(out_valid), $past(scan_acc, 2), "result without a scan tick two cycles earlier")

endmodule

bind seven_segment_text_display sstd_checker #(
	.DIGIT_COUNT (DIGIT_COUNT)
) u_sstd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.mode         (mode),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.digit_index  (digit_index),
	.segment_bits (segment_bits)
);

>>> verif/tb_seven_segment_text_display.sv
`timescale 1ns / 100ps
// Self-checking testbench for seven_segment_text_display: a directed script, then random
// character writes and scan ticks checked against an in-bench model of the display store.
// Depends on sstd_pkg and the RTL of the block only.
module tb_seven_segment_text_display;
	import sstd_pkg::*;

	localparam int DIGITS       = DIGIT_COUNT_DEF;
	localparam int RANDOM_ITEMS = 1750;
	localparam int STALL_LIMIT  = 1000;   // cycles with no handshake on either side
	localparam int DRAIN_CYCLES = 8;      // settle time after the last pending result has come out

	// Segment font a..g,dp on bits 7..0, first entry is space (code 32).
	localparam logic [7:0] FONT [0:95] = '{
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h9c, 8'hf0, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00,
		8'hfc, 8'h60, 8'hda, 8'hf2, 8'h66, 8'hb6, 8'hbe, 8'he0,
		8'hfe, 8'hf6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'hee, 8'h3e, 8'h9c, 8'h7a, 8'h9e, 8'h8e, 8'hbc,
		8'h6e, 8'h0c, 8'h70, 8'h00, 8'h1c, 8'h00, 8'h2a, 8'hfc,
		8'hce, 8'he6, 8'h0a, 8'hb6, 8'h1e, 8'h7c, 8'h00, 8'h00,
		8'h00, 8'h76, 8'hda, 8'h9c, 8'h00, 8'hf0, 8'hc4, 8'h10,
		8'h00, 8'hee, 8'h3e, 8'h1a, 8'h7a, 8'hde, 8'h8e, 8'hbc,
		8'h2e, 8'h08, 8'h70, 8'h00, 8'h1c, 8'h00, 8'h2a, 8'h3a,
		8'hce, 8'he6, 8'h0a, 8'hb6, 8'h1e, 8'h38, 8'h00, 8'h00,
		8'h00, 8'h76, 8'hda, 8'h00, 8'h0c, 8'h00, 8'h00, 8'h00
	};

	// One directed request; pinned rows carry a hand-read expected result.
	typedef struct packed {
		logic       m;
		logic [7:0] code;
		logic       pinned;
		logic [1:0] idx;
		logic [7:0] seg;
	} script_row_t;

	typedef struct packed {
		logic [1:0] idx;
		logic [7:0] seg;
	} shown_digit_t;

	localparam int SCRIPT_LEN = 26;
	localparam script_row_t SCRIPT [0:SCRIPT_LEN-1] = '{
		'{MODE_SCAN, 8'h00, 1'b1, 2'd1, 8'h00},   // first tick after reset shows digit 1, blank
		'{MODE_CHAR, 8'h30, 1'b0, 2'd0, 8'h00},   // '0' into digit 0
		'{MODE_CHAR, CH_PERIOD, 1'b0, 2'd0, 8'h00}, // dp on digit 0
		'{MODE_CHAR, 8'h41, 1'b0, 2'd0, 8'h00},   // 'A' into digit 1
		'{MODE_CHAR, 8'hff, 1'b0, 2'd0, 8'h00},   // top code renders blank
		'{MODE_CHAR, 8'h00, 1'b0, 2'd0, 8'h00},   // code zero renders blank, cursor at 4
		'{MODE_CHAR, 8'h43, 1'b0, 2'd0, 8'h00},   // past the store: dropped, cursor still moves
		'{MODE_CHAR, CH_COMMA, 1'b0, 2'd0, 8'h00},  // dp target past the store: no effect
		'{MODE_CHAR, CH_BS, 1'b0, 2'd0, 8'h00},
		'{MODE_CHAR, CH_BS, 1'b0, 2'd0, 8'h00},
		'{MODE_CHAR, CH_COMMA, 1'b0, 2'd0, 8'h00},  // dp on the blank digit 2
		'{MODE_SCAN, 8'hff, 1'b0, 2'd0, 8'h00},   // char_code ignored on a tick
		'{MODE_SCAN, 8'h00, 1'b0, 2'd0, 8'h00},
		'{MODE_SCAN, 8'h00, 1'b1, 2'd0, 8'hfd},   // wrap to digit 0: '0' with dp
		'{MODE_SCAN, 8'h00, 1'b0, 2'd0, 8'h00},
		'{MODE_CHAR, CH_CR, 1'b0, 2'd0, 8'h00},
		'{MODE_CHAR, CH_PERIOD, 1'b0, 2'd0, 8'h00}, // cursor at zero: dp lands on digit 0
		'{MODE_CHAR, 8'h7f, 1'b0, 2'd0, 8'h00},   // last font entry
		'{MODE_CHAR, 8'h80, 1'b0, 2'd0, 8'h00},   // first code above the font
		'{MODE_CHAR, CH_LF, 1'b0, 2'd0, 8'h00},
		'{MODE_SCAN, 8'h00, 1'b1, 2'd2, 8'h00},   // store blanked by newline
		'{MODE_CHAR, CH_BS, 1'b0, 2'd0, 8'h00},   // backspace at zero stays at zero
		'{MODE_CHAR, 8'h5b, 1'b0, 2'd0, 8'h00},
		'{MODE_CHAR, 8'h09, 1'b0, 2'd0, 8'h00},   // other control code: blank, cursor moves
		'{MODE_SCAN, 8'h00, 1'b0, 2'd0, 8'h00},
		'{MODE_SCAN, 8'h00, 1'b0, 2'd0, 8'h00}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       mode = MODE_CHAR;
	logic [7:0] char_code = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] digit_index;
	logic [7:0] segment_bits;

	// hand-read expectation riding along with the current request
	logic       pin_on = 1'b0;
	logic [1:0] pin_idx = 2'd0;
	logic [7:0] pin_seg = 8'h00;

	// shadow of the display state
	logic [7:0] shadow_digits [0:DIGITS-1];
	int         shadow_cursor;
	int         shadow_scan;

	shown_digit_t pending_digits[$];
	int           fail_count = 0;
	int           idle_cycles = 0;
	bit           quiet = 1'b0;    // no idling on either side while set

	seven_segment_text_display #(
		.DIGIT_COUNT(DIGITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.char_code   (char_code),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digit_index (digit_index),
		.segment_bits(segment_bits)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Applies one accepted request to the shadow state; a scan tick yields a shown digit.
	function automatic void display_step(input logic m, input logic [7:0] code,
			output bit emits, output shown_digit_t shown);
		int prior;
		emits = 1'b0;
		shown = '0;
		prior = (shadow_cursor > 0) ? shadow_cursor - 1 : 0;
		if (m == MODE_SCAN) begin
			shadow_scan = (shadow_scan + 1) % DIGITS;
			shown.idx = shadow_scan[1:0];
			shown.seg = shadow_digits[shadow_scan];
			emits = 1'b1;
		end else if (code == CH_BS) begin
			shadow_cursor = prior;
		end else if (code == CH_LF) begin
			foreach (shadow_digits[k])
				shadow_digits[k] = 8'h00;
			shadow_cursor = 0;
		end else if (code == CH_CR) begin
			shadow_cursor = 0;
		end else if (code == CH_PERIOD || code == CH_COMMA) begin
			// dp goes on the digit left of the cursor
			if (prior < DIGITS)
				shadow_digits[prior] = shadow_digits[prior] | 8'h01;
		end else begin
			if (shadow_cursor < DIGITS)
				shadow_digits[shadow_cursor] =
					(code >= 8'd32 && code <= 8'd127) ? FONT[code - 8'd32] : 8'h00;
			if (shadow_cursor < 255)
				shadow_cursor = shadow_cursor + 1;
		end
	endfunction

	// Predict on each accepted request, check each accepted result in order.
	always @(posedge clk) begin : monitor
		bit           emits;
		shown_digit_t shown;
		shown_digit_t want;
		if (arst_n && in_valid && in_ready) begin
			display_step(mode, char_code, emits, shown);
			if (emits)
				pending_digits.push_back(pin_on ? shown_digit_t'{pin_idx, pin_seg} : shown);
		end
		if (arst_n && out_valid && out_ready) begin
			if (pending_digits.size() == 0) begin
				$display("%0t: unexpected result digit_index %0d segment_bits %h",
					$time, digit_index, segment_bits);
				fail_count++;
			end else begin
				want = pending_digits.pop_front();
				if (digit_index !== want.idx) begin
					$display("%0t: digit_index expected %0d, got %0d",
						$time, want.idx, digit_index);
					fail_count++;
				end
				if (segment_bits !== want.seg) begin
					$display("%0t: segment_bits expected %h, got %h",
						$time, want.seg, segment_bits);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: ends the run if neither side moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result side back-pressure, about one stall cycle in four outside the quiet stretch.
	always @(negedge clk)
		out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 24);

	// Presents one request from a falling edge and holds it until accepted.
	task automatic send_request(input logic m, input logic [7:0] code, input logic pin,
			input logic [1:0] pidx, input logic [7:0] pseg);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 24) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= m;
		char_code <= code;
		pin_on    <= pin;
		pin_idx   <= pidx;
		pin_seg   <= pseg;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Sender holds off until every pending result has come out.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_digits.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		logic       m;
		logic [7:0] code;
		int         pick;
		bit         burst;

		foreach (shadow_digits[k])
			shadow_digits[k] = 8'h00;
		shadow_cursor = 0;
		shadow_scan   = 0;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed script
		for (int r = 0; r < SCRIPT_LEN; r++)
			send_request(SCRIPT[r].m, SCRIPT[r].code, SCRIPT[r].pinned,
				SCRIPT[r].idx, SCRIPT[r].seg);
		drain_results();

		// random traffic
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 600)
				drain_results();
			quiet = (n >= 1200 && n < 1450);
			// long forward-only run drives the cursor into saturation at 255
			burst = (n >= 700 && n < 1100);
			pick  = $urandom_range(99);
			code  = 8'($urandom);
			if (pick < (burst ? 15 : 35)) begin
				m = MODE_SCAN;
			end else begin
				m = MODE_CHAR;
				if (burst) begin
					while (code == CH_LF || code == CH_CR || code == CH_BS)
						code = 8'($urandom);
				end else begin
					pick = $urandom_range(99);
					if (pick < 8)
						code = CH_LF;
					else if (pick < 14)
						code = CH_CR;
					else if (pick < 24)
						code = CH_BS;
					else if (pick < 34)
						code = pick[0] ? CH_PERIOD : CH_COMMA;
					else if (pick >= 50)
						code = 8'($urandom_range(32, 127));
				end
			end
			send_request(m, code, 1'b0, 2'd0, 8'h00);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_digits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
